// ===== src/ket_pkg.sv =====
`default_nettype none
package ket_pkg;

  localparam int TABLES  = 4;
  localparam int ENTRIES = 256;
  localparam int LANES   = 4;
  localparam int ROWS    = ENTRIES / LANES;
  localparam int DEPTH   = TABLES * ROWS;

  localparam int TID_W  = $clog2(TABLES);
  localparam int LANE_W = $clog2(LANES);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int SLOT_W = ROW_W + LANE_W;
  localparam int ADDR_W = TID_W + ROW_W;
  localparam int CAP_W  = 9;

  localparam logic [2:0] CMD_INIT = 3'd0;
  localparam logic [2:0] CMD_FREE = 3'd1;
  localparam logic [2:0] CMD_ADD  = 3'd2;
  localparam logic [2:0] CMD_INS  = 3'd3;
  localparam logic [2:0] CMD_LOOK = 3'd4;
  localparam logic [2:0] CMD_READ = 3'd5;
  localparam logic [2:0] CMD_DELK = 3'd6;
  localparam logic [2:0] CMD_DELI = 3'd7;

  typedef struct packed {
    logic [2:0]  command;
    logic [1:0]  table_id;
    logic [8:0]  capacity;
    logic [7:0]  index;
    logic [15:0] key_port;
    logic [11:0] key_vlan;
    logic [31:0] value;
  } in_t;

  typedef struct packed {
    logic        status;
    logic [7:0]  found_index;
    logic [15:0] rec_port;
    logic [11:0] rec_vlan;
    logic [31:0] rec_value;
  } out_t;

  typedef struct packed {
    logic [15:0] port;
    logic [11:0] vlan;
    logic [31:0] value;
  } rec_t;

  typedef struct packed {
    logic vld;
    rec_t rec;
  } word_t;

  localparam int WORD_W = $bits(word_t);

  // first hit and first free slot seen so far along the chain
  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] hit_slot;
    rec_t              rec;
    logic              fre;
    logic [SLOT_W-1:0] fre_slot;
  } link_t;

  typedef struct packed {
    logic              all;
    logic              one;
    logic [LANE_W-1:0] lane;
    logic [ADDR_W-1:0] addr;
    word_t             word;
  } wr_ctl_t;

  typedef struct packed {
    logic              mode_idx;
    logic [ROW_W-1:0]  row;
    logic [15:0]       port;
    logic [11:0]       vlan;
    logic [7:0]        idx;
    logic [CAP_W-1:0]  cap;
  } cmp_t;

endpackage
`default_nettype wire

// ===== src/ket_ram.sv =====
`default_nettype none
module ket_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== src/ket_cell.sv =====
`default_nettype none
module ket_cell (
  input  wire logic                       clk,
  input  wire logic [ket_pkg::LANE_W-1:0] lane_id,
  input  wire logic [ket_pkg::ADDR_W-1:0] rd_addr,
  input  wire ket_pkg::wr_ctl_t           wr,
  input  wire ket_pkg::cmp_t              cmp,
  input  wire ket_pkg::link_t             prev,
  output ket_pkg::link_t                  next
);

  ket_pkg::word_t                   rd_word;
  logic [ket_pkg::WORD_W-1:0]       rd_bits;
  logic [ket_pkg::SLOT_W-1:0]       slot;
  logic                             in_cap;
  logic                             hit;
  logic                             fre;

  ket_ram #(.WIDTH(ket_pkg::WORD_W), .DEPTH(ket_pkg::DEPTH)) u_ram (
    .clk   (clk),
    .we    (wr.all || (wr.one && wr.lane == lane_id)),
    .waddr (wr.addr),
    .wdata (wr.word),
    .raddr (rd_addr),
    .rdata (rd_bits)
  );

  assign rd_word = rd_bits;
  assign slot    = {cmp.row, lane_id};
  assign in_cap  = ket_pkg::CAP_W'(slot) < cmp.cap;
  assign hit = rd_word.vld && in_cap &&
               (cmp.mode_idx ? (slot == ket_pkg::SLOT_W'(cmp.idx))
                             : (rd_word.rec.port == cmp.port &&
                                rd_word.rec.vlan == cmp.vlan));
  assign fre = !rd_word.vld && in_cap;

  // lower lanes win, so an earlier hit passes through untouched
  always_comb begin
    next = prev;
    if (!prev.hit && hit) begin
      next.hit      = 1'b1;
      next.hit_slot = slot;
      next.rec      = rd_word.rec;
    end
    if (!prev.fre && fre) begin
      next.fre      = 1'b1;
      next.fre_slot = slot;
    end
  end

endmodule
`default_nettype wire

// ===== src/keyed_entry_table_core.sv =====
// from accept to out_valid: key commands scan rows up to the capacity, four slots
//   compared per cycle by the lane chain; index commands read one row; init and free
//   clear the table, a row per cycle; errors and zero-capacity key commands skip the scan
// throughput: one transaction at a time, the next taken the cycle after the result is
//   posted; a stalled result holds the following one in its last state
// reset: synchronous active low, then every row of all tables is cleared with in_ready low
`default_nettype none
module keyed_entry_table_core (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire ket_pkg::in_t   in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output ket_pkg::out_t       out_data
);

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_SCAN   = 6'b000100,
    ST_DECIDE = 6'b001000,
    ST_SWEEP  = 6'b010000,
    ST_RESP   = 6'b100000
  } state_t;

  state_t                       state_r, state_nxt;
  logic                         act_r [ket_pkg::TABLES];
  logic                         act_nxt [ket_pkg::TABLES];
  logic [ket_pkg::CAP_W-1:0]    cap_r [ket_pkg::TABLES];
  logic [ket_pkg::CAP_W-1:0]    cap_nxt [ket_pkg::TABLES];
  ket_pkg::in_t                 req_r, req_nxt;
  logic [ket_pkg::CAP_W-1:0]    cur_cap_r, cur_cap_nxt;
  logic                         mode_idx_r, mode_idx_nxt;
  logic [ket_pkg::ROW_W:0]      rd_row_r, rd_row_nxt;
  logic [ket_pkg::ROW_W-1:0]    end_row_r, end_row_nxt;
  logic                         dvld_r, dvld_nxt;
  logic [ket_pkg::ROW_W-1:0]    drow_r, drow_nxt;
  ket_pkg::link_t               best_r, best_nxt;
  ket_pkg::out_t                res_r, res_nxt;
  logic [ket_pkg::ADDR_W-1:0]   cnt_r, cnt_nxt;
  logic                         out_valid_r, out_valid_nxt;
  ket_pkg::out_t                out_data_r, out_data_nxt;

  ket_pkg::wr_ctl_t             wr;
  ket_pkg::cmp_t                cmp;
  ket_pkg::link_t               chain [ket_pkg::LANES+1];
  logic [ket_pkg::TID_W-1:0]    tid_in;
  logic [ket_pkg::TID_W-1:0]    tid_r;
  logic                         issue;

  assign tid_in    = in_data.table_id[ket_pkg::TID_W-1:0];
  assign tid_r     = req_r.table_id[ket_pkg::TID_W-1:0];
  assign issue     = (state_r == ST_SCAN) && (rd_row_r <= {1'b0, end_row_r});
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign cmp.mode_idx = mode_idx_r;
  assign cmp.row      = drow_r;
  assign cmp.port     = req_r.key_port;
  assign cmp.vlan     = req_r.key_vlan;
  assign cmp.idx      = req_r.index;
  assign cmp.cap      = cur_cap_r;

  assign chain[0] = '0;

  for (genvar g = 0; g < ket_pkg::LANES; g++) begin : g_lane
    ket_cell u_cell (
      .clk     (clk),
      .lane_id (ket_pkg::LANE_W'(g)),
      .rd_addr ({tid_r, rd_row_r[ket_pkg::ROW_W-1:0]}),
      .wr      (wr),
      .cmp     (cmp),
      .prev    (chain[g]),
      .next    (chain[g+1])
    );
  end

  always_comb begin
    logic                      dec_ok;
    logic                      dec_wr;
    logic [ket_pkg::SLOT_W-1:0] dec_slot;
    logic                      tid_ok;

    state_nxt     = state_r;
    act_nxt       = act_r;
    cap_nxt       = cap_r;
    req_nxt       = req_r;
    cur_cap_nxt   = cur_cap_r;
    mode_idx_nxt  = mode_idx_r;
    rd_row_nxt    = rd_row_r;
    end_row_nxt   = end_row_r;
    dvld_nxt      = 1'b0;
    drow_nxt      = drow_r;
    best_nxt      = best_r;
    res_nxt       = res_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    wr            = '0;
    dec_ok        = 1'b0;
    dec_wr        = 1'b0;
    dec_slot      = '0;
    tid_ok        = 32'(in_data.table_id) < ket_pkg::TABLES;

    unique case (state_r)
      ST_CLEAR: begin
        wr.all  = 1'b1;
        wr.addr = cnt_r;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == ket_pkg::ADDR_W'(ket_pkg::DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          req_nxt      = in_data;
          res_nxt      = '0;
          best_nxt     = '0;
          cnt_nxt      = '0;
          mode_idx_nxt = (in_data.command == ket_pkg::CMD_READ) ||
                         (in_data.command == ket_pkg::CMD_DELI);
          if (!tid_ok) begin
            res_nxt.status = 1'b1;
            state_nxt      = ST_RESP;
          end else begin
            cur_cap_nxt = cap_r[tid_in];
            if (in_data.command == ket_pkg::CMD_INIT) begin
              if (act_r[tid_in]) begin
                res_nxt.status = 1'b1;
                state_nxt      = ST_RESP;
              end else begin
                act_nxt[tid_in] = 1'b1;
                cap_nxt[tid_in] =
                  (in_data.capacity > ket_pkg::CAP_W'(ket_pkg::ENTRIES)) ?
                  ket_pkg::CAP_W'(ket_pkg::ENTRIES) : in_data.capacity;
                state_nxt = ST_SWEEP;
              end
            end else if (!act_r[tid_in]) begin
              res_nxt.status = 1'b1;
              state_nxt      = ST_RESP;
            end else if (in_data.command == ket_pkg::CMD_FREE) begin
              act_nxt[tid_in] = 1'b0;
              cap_nxt[tid_in] = '0;
              state_nxt       = ST_SWEEP;
            end else if (mode_idx_nxt) begin
              if (ket_pkg::CAP_W'(in_data.index) >= cap_r[tid_in]) begin
                res_nxt.status = 1'b1;
                state_nxt      = ST_RESP;
              end else begin
                end_row_nxt = ket_pkg::ROW_W'(in_data.index >> ket_pkg::LANE_W);
                rd_row_nxt  = {1'b0, end_row_nxt};
                state_nxt   = ST_SCAN;
              end
            end else if (cap_r[tid_in] == '0) begin
              state_nxt = ST_DECIDE;
            end else begin
              end_row_nxt = ket_pkg::ROW_W'((cap_r[tid_in] - 1'b1) >> ket_pkg::LANE_W);
              rd_row_nxt  = '0;
              state_nxt   = ST_SCAN;
            end
          end
        end
      end
      ST_SCAN: begin
        dvld_nxt = issue;
        drow_nxt = rd_row_r[ket_pkg::ROW_W-1:0];
        if (issue) begin
          rd_row_nxt = rd_row_r + 1'b1;
        end
        if (dvld_r) begin
          if (!best_r.hit && chain[ket_pkg::LANES].hit) begin
            best_nxt.hit      = 1'b1;
            best_nxt.hit_slot = chain[ket_pkg::LANES].hit_slot;
            best_nxt.rec      = chain[ket_pkg::LANES].rec;
          end
          if (!best_r.fre && chain[ket_pkg::LANES].fre) begin
            best_nxt.fre      = 1'b1;
            best_nxt.fre_slot = chain[ket_pkg::LANES].fre_slot;
          end
          if (drow_r == end_row_r) begin
            state_nxt = ST_DECIDE;
          end
        end
      end
      ST_DECIDE: begin
        unique case (req_r.command) inside
          ket_pkg::CMD_ADD: begin
            dec_ok   = best_r.hit || best_r.fre;
            dec_wr   = dec_ok;
            dec_slot = best_r.hit ? best_r.hit_slot : best_r.fre_slot;
          end
          ket_pkg::CMD_INS: begin
            dec_ok   = best_r.fre;
            dec_wr   = dec_ok;
            dec_slot = best_r.fre_slot;
          end
          ket_pkg::CMD_DELK, ket_pkg::CMD_DELI: begin
            dec_ok   = best_r.hit;
            dec_wr   = dec_ok;
            dec_slot = best_r.hit_slot;
          end
          default: begin
            dec_ok   = best_r.hit;
            dec_slot = best_r.hit_slot;
          end
        endcase
        wr.one          = dec_wr;
        wr.lane         = dec_slot[ket_pkg::LANE_W-1:0];
        wr.addr         = {tid_r, dec_slot[ket_pkg::SLOT_W-1:ket_pkg::LANE_W]};
        wr.word.vld     = (req_r.command == ket_pkg::CMD_ADD) ||
                          (req_r.command == ket_pkg::CMD_INS);
        wr.word.rec     = {req_r.key_port, req_r.key_vlan, req_r.value};
        res_nxt         = '0;
        res_nxt.status  = !dec_ok;
        if (dec_ok) begin
          res_nxt.found_index = 8'(dec_slot);
          if ((req_r.command == ket_pkg::CMD_LOOK) ||
              (req_r.command == ket_pkg::CMD_READ)) begin
            res_nxt.rec_port  = best_r.rec.port;
            res_nxt.rec_vlan  = best_r.rec.vlan;
            res_nxt.rec_value = best_r.rec.value;
          end
        end
        state_nxt = ST_RESP;
      end
      ST_SWEEP: begin
        wr.all  = 1'b1;
        wr.addr = {tid_r, cnt_r[ket_pkg::ROW_W-1:0]};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r[ket_pkg::ROW_W-1:0] == ket_pkg::ROW_W'(ket_pkg::ROWS - 1)) begin
          state_nxt = ST_RESP;
        end
      end
      ST_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      dvld_r      <= 1'b0;
      for (int i = 0; i < ket_pkg::TABLES; i++) begin
        act_r[i] <= 1'b0;
        cap_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      dvld_r      <= dvld_nxt;
      act_r       <= act_nxt;
      cap_r       <= cap_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    cur_cap_r  <= cur_cap_nxt;
    mode_idx_r <= mode_idx_nxt;
    rd_row_r   <= rd_row_nxt;
    end_row_r  <= end_row_nxt;
    drow_r     <= drow_nxt;
    best_r     <= best_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
`default_nettype wire

// ===== src/ket_chk.sv =====
`default_nettype none
module ket_chk (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          in_valid,
  input wire logic          in_ready,
  input wire logic          out_valid,
  input wire logic          out_ready,
  input wire ket_pkg::out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status |->
      out_data.found_index == '0 && out_data.rec_port == '0 &&
      out_data.rec_vlan == '0 && out_data.rec_value == '0)
    else $error("error result carries data");

  a_one_at_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction taken while busy");

endmodule

bind keyed_entry_table_core ket_chk u_ket_chk (.*);
`default_nettype wire

// ===== sim/keyed_entry_table_core_tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
module keyed_entry_table_core_tb;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  ket_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  ket_pkg::out_t out_data;

  keyed_entry_table_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // shadow copy of the tables
  logic          tbl_on [ket_pkg::TABLES];
  int            tbl_cap [ket_pkg::TABLES];
  logic          slot_used [ket_pkg::TABLES*ket_pkg::ENTRIES];
  ket_pkg::rec_t slot_rec [ket_pkg::TABLES*ket_pkg::ENTRIES];

  ket_pkg::out_t answer_q[$];
  int   errors = 0;
  bit   hold_long = 1'b0;
  bit   stim_done = 1'b0;

  // recent keys, so lookups and deletes hit often
  logic [15:0] key_ports[$];
  logic [11:0] key_vlans[$];

  function automatic ket_pkg::out_t predict_answer(ket_pkg::in_t it);
    ket_pkg::out_t r;
    int base, cap, s;
    r = '0;
    r.status = 1'b1;
    s = -1;
    if (it.table_id >= ket_pkg::TABLES) return r;
    base = it.table_id * ket_pkg::ENTRIES;
    if (it.command == ket_pkg::CMD_INIT) begin
      if (tbl_on[it.table_id]) return r;
      tbl_cap[it.table_id] = (it.capacity > ket_pkg::ENTRIES) ? ket_pkg::ENTRIES
                                                               : it.capacity;
      for (int i = 0; i < ket_pkg::ENTRIES; i++) slot_used[base+i] = 1'b0;
      tbl_on[it.table_id] = 1'b1;
      r.status = 1'b0;
      return r;
    end
    if (!tbl_on[it.table_id]) return r;
    cap = tbl_cap[it.table_id];
    case (it.command)
      ket_pkg::CMD_FREE: begin
        for (int i = 0; i < ket_pkg::ENTRIES; i++) slot_used[base+i] = 1'b0;
        tbl_on[it.table_id] = 1'b0;
        tbl_cap[it.table_id] = 0;
        r.status = 1'b0;
      end
      ket_pkg::CMD_ADD, ket_pkg::CMD_INS, ket_pkg::CMD_LOOK, ket_pkg::CMD_DELK: begin
        if (it.command != ket_pkg::CMD_INS)
          for (int i = 0; i < cap && s < 0; i++)
            if (slot_used[base+i] && slot_rec[base+i].port == it.key_port &&
                slot_rec[base+i].vlan == it.key_vlan) s = i;
        if (it.command == ket_pkg::CMD_ADD || it.command == ket_pkg::CMD_INS) begin
          if (s < 0)
            for (int i = 0; i < cap && s < 0; i++)
              if (!slot_used[base+i]) s = i;
          if (s >= 0) begin
            slot_rec[base+s] = '{it.key_port, it.key_vlan, it.value};
            slot_used[base+s] = 1'b1;
          end
        end
        if (s >= 0) begin
          r.status = 1'b0;
          r.found_index = s[7:0];
          if (it.command == ket_pkg::CMD_LOOK) begin
            r.rec_port = slot_rec[base+s].port;
            r.rec_vlan = slot_rec[base+s].vlan;
            r.rec_value = slot_rec[base+s].value;
          end
          if (it.command == ket_pkg::CMD_DELK) slot_used[base+s] = 1'b0;
        end
      end
      default: begin
        if (it.index < cap && slot_used[base+it.index]) begin
          r.status = 1'b0;
          r.found_index = it.index;
          if (it.command == ket_pkg::CMD_READ) begin
            r.rec_port = slot_rec[base+it.index].port;
            r.rec_vlan = slot_rec[base+it.index].vlan;
            r.rec_value = slot_rec[base+it.index].value;
          end else begin
            slot_used[base+it.index] = 1'b0;
          end
        end
      end
    endcase
    return r;
  endfunction

  function automatic ket_pkg::in_t make_cmd(logic [2:0] c, logic [1:0] t, int cap, int idx,
                                            logic [15:0] p, logic [11:0] v,
                                            logic [31:0] val);
    ket_pkg::in_t it;
    it.command = c;
    it.table_id = t;
    it.capacity = cap[8:0];
    it.index = idx[7:0];
    it.key_port = p;
    it.key_vlan = v;
    it.value = val;
    return it;
  endfunction

  function automatic ket_pkg::in_t random_cmd();
    ket_pkg::in_t it;
    int pick, k;
    it = ket_pkg::in_t'({$urandom, $urandom, $urandom});
    pick = $urandom_range(0, 99);
    if (pick < 3) it.command = ket_pkg::CMD_INIT;
    else if (pick < 5) it.command = ket_pkg::CMD_FREE;
    else if (pick < 98) it.command = 3'($urandom_range(2, 7));
    if (it.command == ket_pkg::CMD_INIT)
      it.capacity = ($urandom_range(0, 9) == 0) ? 9'($urandom_range(0, 511))
                                                  : 9'($urandom_range(0, 12));
    if (it.command inside {ket_pkg::CMD_READ, ket_pkg::CMD_DELI} &&
        $urandom_range(0, 3) != 0)
      it.index = 8'($urandom_range(0, 12));
    if (key_ports.size() > 0 && $urandom_range(0, 3) != 0) begin
      k = $urandom_range(0, key_ports.size() - 1);
      it.key_port = key_ports[k];
      it.key_vlan = key_vlans[k];
    end else if ($urandom_range(0, 1) == 0) begin
      it.key_port = 16'($urandom_range(0, 3));
      it.key_vlan = 12'($urandom_range(0, 1));
    end
    if (it.command inside {ket_pkg::CMD_ADD, ket_pkg::CMD_INS}) begin
      key_ports.push_back(it.key_port);
      key_vlans.push_back(it.key_vlan);
      if (key_ports.size() > 16) begin
        void'(key_ports.pop_front());
        void'(key_vlans.pop_front());
      end
    end
    return it;
  endfunction

  task automatic send_cmd(ket_pkg::in_t it);
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    answer_q.push_back(predict_answer(it));
  endtask

  // directed rows; fixed marks the ones whose answer is typed in
  typedef struct {
    ket_pkg::in_t  cmd;
    bit            fixed;
    ket_pkg::out_t ans;
  } row_t;

  localparam ket_pkg::out_t ANS_OK  = '0;
  localparam ket_pkg::out_t ANS_ERR = {1'b1, 68'd0};

  task automatic run_directed();
    row_t rows[$];
    ket_pkg::out_t ans;
    rows.push_back('{make_cmd(ket_pkg::CMD_LOOK, 0, 0, 0, 1, 1, 0), 1, ANS_ERR});
    rows.push_back('{make_cmd(ket_pkg::CMD_FREE, 1, 0, 0, 0, 0, 0), 1, ANS_ERR});
    rows.push_back('{make_cmd(ket_pkg::CMD_INIT, 0, 2, 0, 0, 0, 0), 1, ANS_OK});
    rows.push_back('{make_cmd(ket_pkg::CMD_INIT, 0, 5, 0, 0, 0, 0), 1, ANS_ERR});
    rows.push_back('{make_cmd(ket_pkg::CMD_INIT, 1, 511, 0, 0, 0, 0), 1, ANS_OK});
    rows.push_back('{make_cmd(ket_pkg::CMD_INIT, 2, 0, 0, 0, 0, 0), 1, ANS_OK});
    rows.push_back('{make_cmd(ket_pkg::CMD_INIT, 3, 256, 0, 0, 0, 0), 1, ANS_OK});
    rows.push_back('{make_cmd(ket_pkg::CMD_ADD, 2, 0, 0, 5, 5, 5), 1, ANS_ERR});
    rows.push_back('{make_cmd(ket_pkg::CMD_ADD, 0, 0, 0, 16'hffff, 12'hfff, 32'hffffffff),
                     0, '0});
    rows.push_back('{make_cmd(ket_pkg::CMD_ADD, 0, 0, 0, 16'hffff, 12'hfff, 32'h1234),
                     0, '0});
    rows.push_back('{make_cmd(ket_pkg::CMD_INS, 0, 0, 0, 16'hffff, 12'hfff, 32'h5678),
                     0, '0});
    rows.push_back('{make_cmd(ket_pkg::CMD_INS, 0, 0, 0, 0, 0, 0), 1, ANS_ERR});
    rows.push_back('{make_cmd(ket_pkg::CMD_LOOK, 0, 0, 0, 16'hffff, 12'hfff, 0), 0, '0});
    rows.push_back('{make_cmd(ket_pkg::CMD_LOOK, 0, 0, 0, 0, 0, 0), 1, ANS_ERR});
    rows.push_back('{make_cmd(ket_pkg::CMD_READ, 0, 0, 1, 0, 0, 0), 0, '0});
    rows.push_back('{make_cmd(ket_pkg::CMD_READ, 0, 0, 2, 0, 0, 0), 1, ANS_ERR});
    rows.push_back('{make_cmd(ket_pkg::CMD_READ, 1, 0, 255, 0, 0, 0), 1, ANS_ERR});
    rows.push_back('{make_cmd(ket_pkg::CMD_DELK, 0, 0, 0, 16'hffff, 12'hfff, 0), 0, '0});
    rows.push_back('{make_cmd(ket_pkg::CMD_DELI, 0, 0, 0, 0, 0, 0), 1, ANS_ERR});
    rows.push_back('{make_cmd(ket_pkg::CMD_DELI, 0, 0, 1, 0, 0, 0), 0, '0});
    rows.push_back('{make_cmd(ket_pkg::CMD_DELK, 0, 0, 0, 16'hffff, 12'hfff, 0),
                     1, ANS_ERR});
    rows.push_back('{make_cmd(ket_pkg::CMD_INS, 3, 0, 0, 0, 0, 32'hffffffff), 0, '0});
    rows.push_back('{make_cmd(ket_pkg::CMD_FREE, 0, 0, 0, 0, 0, 0), 1, ANS_OK});
    rows.push_back('{make_cmd(ket_pkg::CMD_READ, 0, 0, 0, 0, 0, 0), 1, ANS_ERR});
    foreach (rows[i]) begin
      in_valid <= 1'b1;
      in_data <= rows[i].cmd;
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      ans = predict_answer(rows[i].cmd);
      answer_q.push_back(rows[i].fixed ? rows[i].ans : ans);
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    int gap;
    bit drained;
    bit held;
    drained = 1'b0;
    held = 1'b0;
    for (int t = 0; t < ket_pkg::TABLES; t++) begin
      tbl_on[t] = 1'b0;
      tbl_cap[t] = 0;
    end
    for (int i = 0; i < ket_pkg::TABLES*ket_pkg::ENTRIES; i++) begin
      slot_used[i] = 1'b0;
      slot_rec[i] = '0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    for (int n = 0; n < 950; ) begin
      if (n >= 300 && !drained) begin
        // drain everything before going on
        drained = 1'b1;
        in_valid <= 1'b0;
        while (answer_q.size() != 0) @(posedge clk);
      end
      if (n >= 500 && !held) begin
        held = 1'b1;
        hold_long = 1'b1;
      end
      for (int b = $urandom_range(1, 20); b > 0 && n < 950; b--, n++)
        send_cmd(random_cmd());
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  // receiver stall pattern, with one long hold-off
  initial begin
    int phase = 0;
    @(posedge rst_n);
    forever begin
      if (hold_long) begin
        hold_long = 1'b0;
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      phase++;
      if ((phase / 64) % 3 == 0) out_ready <= 1'b1;
      else out_ready <= ((phase % 5) != 0) && ($urandom_range(0, 3) != 0);
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    ket_pkg::out_t e;
    if (rst_n && out_valid && out_ready) begin
      if (answer_q.size() == 0) begin
        $error("unexpected transaction %h", out_data);
        errors++;
      end else begin
        e = answer_q.pop_front();
        if (out_data.status !== e.status) begin
          $error("status exp %h got %h", e.status, out_data.status); errors++;
        end
        if (out_data.found_index !== e.found_index) begin
          $error("found_index exp %h got %h", e.found_index, out_data.found_index);
          errors++;
        end
        if (out_data.rec_port !== e.rec_port) begin
          $error("rec_port exp %h got %h", e.rec_port, out_data.rec_port); errors++;
        end
        if (out_data.rec_vlan !== e.rec_vlan) begin
          $error("rec_vlan exp %h got %h", e.rec_vlan, out_data.rec_vlan); errors++;
        end
        if (out_data.rec_value !== e.rec_value) begin
          $error("rec_value exp %h got %h", e.rec_value, out_data.rec_value); errors++;
        end
      end
    end
  end

  initial begin
    #12ms;
    $display("tb: failure");
    $finish;
  end
endmodule
`default_nettype wire

// ===== keyed_entry_table_core.f =====
src/ket_pkg.sv
src/ket_ram.sv
src/ket_cell.sv
src/keyed_entry_table_core.sv
src/ket_chk.sv
sim/keyed_entry_table_core_tb.sv
